@@ rtl/core/bpool_pkg.sv @@
// Shared types and codes for the buffer pool pin/LRU manager.
package bpool_pkg;

  // command kinds as they arrive on the input channel
  localparam logic [2:0] OP_GET     = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_UNPIN   = 3'd2;
  localparam logic [2:0] OP_DISPOSE = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PINNED     = 3'd1;
  localparam logic [2:0] ST_NO_BUF     = 3'd2;
  localparam logic [2:0] ST_ALREADY    = 3'd3;
  localparam logic [2:0] ST_NOT_PINNED = 3'd4;
  localparam logic [2:0] ST_NOT_BUF    = 3'd5;

  localparam logic [4:0] PIN_MAX = 5'd31;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  file_id;
    logic [23:0] block_num;
    logic [3:0]  open_slot;
    logic        mark_dirty;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  frame;
    logic        load_needed;
    logic        zero_fill;
    logic        write_back;
    logic [7:0]  wb_file;
    logic [23:0] wb_block;
    logic        last;
  } out_item_t;

  // head of the command queue as seen by the engine
  typedef struct packed {
    logic     valid;
    in_item_t cmd;
  } cmd_slot_t;

endpackage

@@ rtl/core/bpool_front.sv @@
// Command front end: drops unknown kinds and queues commands for the engine.
module bpool_front
  import bpool_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output cmd_slot_t q_head,
  input  logic      q_pop
);

  in_item_t   q_mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       known;
  logic       push;

  // classify: only the six defined kinds go on to the engine
  always_comb begin
    unique case (in_data.kind)
      OP_GET, OP_ALLOC, OP_UNPIN, OP_DISPOSE, OP_FLUSH, OP_CLEAR: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy && known;

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_mem_r[rptr_r];

  // two-entry queue pointers
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= in_data;
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && !q_pop |=> cnt_r == 2'd2) else $error("queue count lost");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue overflow");
`endif

endmodule

@@ rtl/core/bpool_engine.sv @@
// Frame table and sequencer: walks all frames once per command, then updates; a flush may stop early.
module bpool_engine
  import bpool_pkg::*;
#(
  parameter int FRAMES     = 32,
  parameter int OPENINGS   = 16,
  parameter int FILE_BITS  = 8,
  parameter int BLOCK_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_slot_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [FW-1:0] LAST_IDX = FW'(FRAMES - 1);

  // tag and stamp memories (registered read)
  logic [FILE_BITS-1:0]  ftag_mem  [FRAMES];
  logic [BLOCK_BITS-1:0] btag_mem  [FRAMES];
  logic [31:0]           stamp_mem [FRAMES];
  logic [FILE_BITS-1:0]  rd_ft_r;
  logic [BLOCK_BITS-1:0] rd_bt_r;
  logic [31:0]           rd_st_r;

  // per-frame flags in flops
  logic [FRAMES-1:0]   valid_r;
  logic [FRAMES-1:0]   dirty_r;
  logic [4:0]          pcnt_r  [FRAMES];
  logic [OPENINGS-1:0] pbits_r [FRAMES];

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          ev_r, ev_nxt;
  logic [FW-1:0] ev_idx_r, ev_idx_nxt;
  logic [31:0]   use_clk_r, use_clk_nxt;

  logic                  hit_r, hit_nxt;
  logic [FW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [OPENINGS-1:0]   hit_pb_r, hit_pb_nxt;
  logic [4:0]            hit_pc_r, hit_pc_nxt;
  logic                  free_r, free_nxt;
  logic [FW-1:0]         free_idx_r, free_idx_nxt;
  logic                  lru_r, lru_nxt;
  logic [FW-1:0]         lru_idx_r, lru_idx_nxt;
  logic [31:0]           lru_st_r, lru_st_nxt;
  logic                  lru_dirty_r, lru_dirty_nxt;
  logic [FILE_BITS-1:0]  lru_ft_r, lru_ft_nxt;
  logic [BLOCK_BITS-1:0] lru_bt_r, lru_bt_nxt;
  logic                  disp_r, disp_nxt;
  logic [FW-1:0]         disp_idx_r, disp_idx_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // command decode
  logic [FILE_BITS-1:0]  f_tag;
  logic [BLOCK_BITS-1:0] b_tag;
  logic [OPENINGS-1:0]   pin_bit;
  logic                  is_alloc;

  // frame under evaluation
  logic                  e_v, e_d, tag_hit, file_hit;
  logic [4:0]            e_pc;
  logic [OPENINGS-1:0]   e_pb;

  // write port controls
  logic                  rd_en;
  logic [FW-1:0]         wr_idx;
  logic                  we_valid, wd_valid;
  logic                  we_dirty, wd_dirty;
  logic                  we_pc;
  logic [4:0]            wd_pc;
  logic                  we_pb;
  logic [OPENINGS-1:0]   wd_pb;
  logic                  we_tag, we_stamp;
  logic [FW-1:0]         pick;
  logic                  pick_ok;

  assign f_tag    = FILE_BITS'(q_head.cmd.file_id);
  assign b_tag    = BLOCK_BITS'(q_head.cmd.block_num);
  assign pin_bit  = (32'(q_head.cmd.open_slot) < 32'(OPENINGS)) ?
                    (OPENINGS'(1) << q_head.cmd.open_slot) : '0;
  assign is_alloc = (q_head.cmd.kind == OP_ALLOC);

  assign e_v      = valid_r[ev_idx_r];
  assign e_d      = dirty_r[ev_idx_r];
  assign e_pc     = pcnt_r[ev_idx_r];
  assign e_pb     = pbits_r[ev_idx_r];
  assign file_hit = e_v && (rd_ft_r == f_tag);
  assign tag_hit  = file_hit && (rd_bt_r == b_tag);

  assign pick    = free_r ? free_idx_r : lru_idx_r;
  assign pick_ok = free_r || lru_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    ev_nxt        = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    use_clk_nxt   = use_clk_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_pb_nxt    = hit_pb_r;
    hit_pc_nxt    = hit_pc_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    lru_nxt       = lru_r;
    lru_idx_nxt   = lru_idx_r;
    lru_st_nxt    = lru_st_r;
    lru_dirty_nxt = lru_dirty_r;
    lru_ft_nxt    = lru_ft_r;
    lru_bt_nxt    = lru_bt_r;
    disp_nxt      = disp_r;
    disp_idx_nxt  = disp_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    wr_idx        = ev_idx_r;
    we_valid      = 1'b0;
    wd_valid      = 1'b0;
    we_dirty      = 1'b0;
    wd_dirty      = 1'b0;
    we_pc         = 1'b0;
    wd_pc         = 5'd0;
    we_pb         = 1'b0;
    wd_pb         = '0;
    we_tag        = 1'b0;
    we_stamp      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          state_nxt  = S_WALK;
          rd_cnt_nxt = '0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          lru_nxt    = 1'b0;
          disp_nxt   = 1'b0;
        end
      end

      S_WALK: begin
        // issue the next frame read
        if (rd_cnt_r != CW'(FRAMES)) begin
          rd_en      = 1'b1;
          ev_nxt     = 1'b1;
          ev_idx_nxt = rd_cnt_r[FW-1:0];
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end
        // evaluate the frame read last cycle
        if (ev_r) begin
          if (tag_hit && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = ev_idx_r;
            hit_pb_nxt  = e_pb;
            hit_pc_nxt  = e_pc;
          end
          if (!e_v && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = ev_idx_r;
          end
          if ((e_pc == 5'd0) && (!lru_r || (rd_st_r < lru_st_r))) begin
            lru_nxt       = 1'b1;
            lru_idx_nxt   = ev_idx_r;
            lru_st_nxt    = rd_st_r;
            lru_dirty_nxt = e_d;
            lru_ft_nxt    = rd_ft_r;
            lru_bt_nxt    = rd_bt_r;
          end
          if (tag_hit && (e_pc == 5'd0) && !disp_r) begin
            disp_nxt     = 1'b1;
            disp_idx_nxt = ev_idx_r;
          end
          if (ev_idx_r == LAST_IDX) begin
            state_nxt = S_FIN;
          end
          if (q_head.cmd.kind == OP_CLEAR && file_hit) begin
            we_valid = 1'b1;
            wd_valid = 1'b0;
          end
          if (q_head.cmd.kind == OP_FLUSH && file_hit) begin
            if ((e_pb & pin_bit) != '0) begin
              // pinned by this opening: stop the walk
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_PINNED;
              out_data_nxt.last   = 1'b1;
              q_pop               = 1'b1;
              ev_nxt              = 1'b0;
              state_nxt           = S_IDLE;
            end else if (e_pc == 5'd0 && e_d) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.status     = ST_OK;
              out_data_nxt.frame      = 5'(ev_idx_r);
              out_data_nxt.write_back = 1'b1;
              out_data_nxt.wb_file    = 8'(rd_ft_r);
              out_data_nxt.wb_block   = 24'(rd_bt_r);
              we_dirty                = 1'b1;
              wd_dirty                = 1'b0;
            end
          end
        end
      end

      S_FIN: begin
        out_valid_nxt     = 1'b1;
        out_data_nxt.last = 1'b1;
        q_pop             = 1'b1;
        state_nxt         = S_IDLE;
        unique case (q_head.cmd.kind)
          OP_GET, OP_ALLOC: begin
            if (hit_r) begin
              out_data_nxt.frame = 5'(hit_idx_r);
              if (is_alloc) begin
                out_data_nxt.status = ST_ALREADY;
              end else begin
                wr_idx      = hit_idx_r;
                we_stamp    = 1'b1;
                use_clk_nxt = (use_clk_r == '1) ? use_clk_r : use_clk_r + 32'd1;
                we_pc       = 1'b1;
                wd_pc       = (hit_pc_r < PIN_MAX) ? hit_pc_r + 5'd1 : hit_pc_r;
                we_pb       = 1'b1;
                wd_pb       = hit_pb_r | pin_bit;
              end
            end else if (!pick_ok) begin
              out_data_nxt.status = ST_NO_BUF;
            end else begin
              wr_idx      = pick;
              we_valid    = 1'b1;
              wd_valid    = 1'b1;
              we_tag      = 1'b1;
              we_stamp    = 1'b1;
              use_clk_nxt = (use_clk_r == '1) ? use_clk_r : use_clk_r + 32'd1;
              we_pb       = 1'b1;
              wd_pb       = pin_bit;
              we_pc       = 1'b1;
              wd_pc       = 5'd1;
              we_dirty    = 1'b1;
              wd_dirty    = is_alloc;
              out_data_nxt.frame       = 5'(pick);
              out_data_nxt.load_needed = !is_alloc;
              out_data_nxt.zero_fill   = is_alloc;
              if (!free_r && lru_dirty_r) begin
                out_data_nxt.write_back = 1'b1;
                out_data_nxt.wb_file    = 8'(lru_ft_r);
                out_data_nxt.wb_block   = 24'(lru_bt_r);
              end
            end
          end
          OP_UNPIN: begin
            if (!hit_r) begin
              out_data_nxt.status = ST_NOT_BUF;
            end else begin
              out_data_nxt.frame = 5'(hit_idx_r);
              if ((hit_pb_r & pin_bit) == '0) begin
                out_data_nxt.status = ST_NOT_PINNED;
              end else begin
                wr_idx = hit_idx_r;
                we_pb  = 1'b1;
                wd_pb  = hit_pb_r & ~pin_bit;
                we_pc  = 1'b1;
                wd_pc  = (hit_pc_r != 5'd0) ? hit_pc_r - 5'd1 : hit_pc_r;
                if (q_head.cmd.mark_dirty) begin
                  we_dirty = 1'b1;
                  wd_dirty = 1'b1;
                end
              end
            end
          end
          OP_DISPOSE: begin
            if (disp_r) begin
              wr_idx             = disp_idx_r;
              we_valid           = 1'b1;
              wd_valid           = 1'b0;
              out_data_nxt.frame = 5'(disp_idx_r);
            end else begin
              out_data_nxt.status = ST_NOT_BUF;
            end
          end
          default: begin
            // flush and clear close with a plain ok
            out_data_nxt.status = ST_OK;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      ev_r        <= 1'b0;
      use_clk_r   <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      lru_r       <= 1'b0;
      disp_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      ev_r        <= ev_nxt;
      use_clk_r   <= use_clk_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      lru_r       <= lru_nxt;
      disp_r      <= disp_nxt;
    end
  end

  // search payload and result registers
  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_pb_r    <= hit_pb_nxt;
    hit_pc_r    <= hit_pc_nxt;
    free_idx_r  <= free_idx_nxt;
    lru_idx_r   <= lru_idx_nxt;
    lru_st_r    <= lru_st_nxt;
    lru_dirty_r <= lru_dirty_nxt;
    lru_ft_r    <= lru_ft_nxt;
    lru_bt_r    <= lru_bt_nxt;
    disp_idx_r  <= disp_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  // per-frame flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        pcnt_r[i]  <= 5'd0;
        pbits_r[i] <= '0;
      end
    end else begin
      if (we_valid) valid_r[wr_idx] <= wd_valid;
      if (we_dirty) dirty_r[wr_idx] <= wd_dirty;
      if (we_pc)    pcnt_r[wr_idx]  <= wd_pc;
      if (we_pb)    pbits_r[wr_idx] <= wd_pb;
    end
  end

  // tag and stamp memories
  always_ff @(posedge clk) begin
    if (we_tag) begin
      ftag_mem[wr_idx] <= f_tag;
      btag_mem[wr_idx] <= b_tag;
    end
    if (we_stamp) begin
      stamp_mem[wr_idx] <= use_clk_r;
    end
    if (rd_en) begin
      rd_ft_r <= ftag_mem[rd_cnt_r[FW-1:0]];
      rd_bt_r <= btag_mem[rd_cnt_r[FW-1:0]];
      rd_st_r <= stamp_mem[rd_cnt_r[FW-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_fin_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> out_valid_r && out_data_r.last)
    else $error("finish cycle gave no final result");
  a_mid_is_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last |-> out_data_r.write_back)
    else $error("non-final result without write-back");
  a_pop_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r && out_data_r.last)
    else $error("command retired without final result");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> !out_valid_r)
    else $error("result while idle");
`endif

endmodule

@@ rtl/core/buffer_pool_pin_lru_manager.sv @@
// Top level of the buffer pool manager: command queue front end and frame engine.
//
//  channel   ports                       transfer when
//  command   start, busy, in_data        start && !busy
//  result    out_valid, out_data         out_valid (one cycle, no back-pressure)
//
// Each command, once at the queue head, walks all frames: one frame read from the
// tag/stamp memories per cycle, then a final update step. A flush stops early
// at a frame pinned by the opening.
// Reset is synchronous and clears all frames to free; the block is ready at once.
// busy rises only while the two-entry command queue is full.
module buffer_pool_pin_lru_manager
  import bpool_pkg::*;
#(
  parameter int FRAMES     = 32,
  parameter int OPENINGS   = 16,
  parameter int FILE_BITS  = 8,
  parameter int BLOCK_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  cmd_slot_t q_head;
  logic      q_pop;

  bpool_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  bpool_engine #(
    .FRAMES     (FRAMES),
    .OPENINGS   (OPENINGS),
    .FILE_BITS  (FILE_BITS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
